### rtl/flt_pkg.sv
// Shared types and constants for the failed-login source tracker.
// Used by the tracker cells, the cell chain and the top level; no dependencies.
package flt_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int MAX_FLAGS   = 256;

  localparam int STEP_W = $clog2(TABLE_DEPTH);
  localparam int USED_W = $clog2(TABLE_DEPTH + 1);
  localparam int FLAG_W = $clog2(MAX_FLAGS + 1);

  localparam logic [15:0] THRESH_RESET = 16'd3;

  typedef struct packed {
    logic [31:0] addr;
    logic [15:0] count;
    logic        mark;
  } entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_WRAP
  } state_t;

endpackage

### rtl/flt_cell.sv
// One table cell: holds one source entry and passes it to its neighbor on shift.
// Depends on flt_pkg for the entry type.
module flt_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            shift,
  input  logic            clear_mark,
  input  flt_pkg::entry_t d,
  output flt_pkg::entry_t q
);
  import flt_pkg::*;

  always_ff @(posedge clk) begin
    if (shift) begin
      q.addr  <= d.addr;
      q.count <= d.count;
    end
    if (rst || clear_mark) begin
      q.mark <= 1'b0;
    end else if (shift) begin
      q.mark <= d.mark;
    end
  end

endmodule

### rtl/flt_chain.sv
// Row of tracker cells forming a shift ring; the head entry leaves at cell zero
// and the controller feeds the tail. Depends on flt_pkg and flt_cell.
module flt_chain (
  input  logic            clk,
  input  logic            rst,
  input  logic            shift,
  input  logic            clear_mark,
  input  flt_pkg::entry_t tail_d,
  output flt_pkg::entry_t head_q
);
  import flt_pkg::*;

  entry_t cell_q [TABLE_DEPTH];

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    entry_t cell_d;
    if (i == TABLE_DEPTH - 1) begin : g_tail
      assign cell_d = tail_d;
    end else begin : g_body
      assign cell_d = cell_q[i + 1];
    end
    flt_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .shift      (shift),
      .clear_mark (clear_mark),
      .d          (cell_d),
      .q          (cell_q[i])
    );
  end

  assign head_q = cell_q[0];

endmodule

### rtl/failed_login_source_tracker.sv
// Top level of the failed-login source tracker: control, scan counters and outputs.
// Depends on flt_pkg and flt_chain.
//
// A transaction is accepted at a rising edge with start high and busy low.
// Each transaction yields one result, shown for exactly one cycle while done
// is high; the receiver cannot stall it. The fail threshold is written through
// cfg_valid/cfg_ready/cfg_data, and cfg_ready is high whenever busy is low.
// A failed-login line with a valid source rotates the whole source table once
// through the head of the cell chain, one entry per cycle, in the search
// state and then passes the wrap state; done is registered from the wrap
// state. All other transactions go from acceptance straight to the wrap
// state. The rotation of the cell chain sets how long a lookup lasts. The
// table keeps its entries across scans; a begin-scan transaction clears
// the scan counters and every cell's mark.
// Synchronous reset empties the table, clears the counters and marks, and
// sets the threshold to 3. There is no clearing pass after reset.
module failed_login_source_tracker (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        req_type,
  input  logic        failed_password,
  input  logic        has_source,
  input  logic        source_valid,
  input  logic [31:0] source_addr,
  input  logic        mentions_sudo,
  input  logic        mentions_ssh,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,
  output logic        done,
  output logic        flagged,
  output logic [31:0] flagged_addr,
  output logic        not_tracked,
  output logic [31:0] scan_failed,
  output logic [31:0] scan_sudo,
  output logic [31:0] scan_ssh,
  output logic [33:0] scan_total
);
  import flt_pkg::*;

  state_t            state, state_next;
  logic [STEP_W-1:0] step;
  logic [USED_W-1:0] used;
  logic [FLAG_W-1:0] flags;
  logic [15:0]       threshold;
  logic [31:0]       addr_q;
  logic              found;
  logic [31:0]       failed_cnt, sudo_cnt, ssh_cnt;

  entry_t head, tail;
  logic   accept, lookup, count_rest, clear_scan;
  logic   hit, append, take, flag_ok, last_step;
  logic [15:0] base_count, new_count;

  assign accept     = start && !busy;
  assign busy       = (state != ST_IDLE);
  assign cfg_ready  = !busy;
  assign clear_scan = accept && req_type;
  assign lookup     = failed_password && has_source && source_valid;
  assign count_rest = !(failed_password && has_source && !source_valid);

  assign scan_failed = failed_cnt;
  assign scan_sudo   = sudo_cnt;
  assign scan_ssh    = ssh_cnt;

  flt_chain u_chain (
    .clk        (clk),
    .rst        (rst),
    .shift      (state == ST_SEARCH),
    .clear_mark (clear_scan),
    .tail_d     (tail),
    .head_q     (head)
  );

  always_comb begin
    last_step  = (step == STEP_W'(TABLE_DEPTH - 1));
    hit        = !found && ({1'b0, step} < used) && (head.addr == addr_q);
    append     = !found && ({1'b0, step} == used);
    take       = hit || append;
    base_count = hit ? head.count : 16'd0;
    new_count  = (&base_count) ? base_count : base_count + 16'd1;
    flag_ok    = take && (new_count >= threshold) && !(hit && head.mark) &&
                 (flags < FLAG_W'(MAX_FLAGS));
    tail       = head;
    if (take) begin
      tail.addr  = addr_q;
      tail.count = new_count;
      tail.mark  = (hit && head.mark) || flag_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = (!req_type && lookup) ? ST_SEARCH : ST_WRAP;
        end
      end
      ST_SEARCH: begin
        if (last_step) begin
          state_next = ST_WRAP;
        end
      end
      ST_WRAP: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold  <= THRESH_RESET;
      used       <= '0;
      flags      <= '0;
      failed_cnt <= '0;
      sudo_cnt   <= '0;
      ssh_cnt    <= '0;
      done       <= 1'b0;
      found      <= 1'b0;
      step       <= '0;
    end else begin
      done <= (state == ST_WRAP);
      if (cfg_valid && cfg_ready) begin
        threshold <= cfg_data;
      end
      if (accept) begin
        step  <= '0;
        found <= 1'b0;
        if (req_type) begin
          flags      <= '0;
          failed_cnt <= '0;
          sudo_cnt   <= '0;
          ssh_cnt    <= '0;
        end else begin
          if (failed_password && !(&failed_cnt)) begin
            failed_cnt <= failed_cnt + 32'd1;
          end
          if (count_rest && mentions_sudo && !(&sudo_cnt)) begin
            sudo_cnt <= sudo_cnt + 32'd1;
          end
          if (count_rest && mentions_ssh && !(&ssh_cnt)) begin
            ssh_cnt <= ssh_cnt + 32'd1;
          end
        end
      end
      if (state == ST_SEARCH) begin
        step <= step + STEP_W'(1);
        if (take) begin
          found <= 1'b1;
        end
        if (append) begin
          used <= used + USED_W'(1);
        end
        if (flag_ok) begin
          flags <= flags + FLAG_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      addr_q       <= source_addr;
      flagged      <= 1'b0;
      flagged_addr <= '0;
      not_tracked  <= 1'b0;
    end
    if (state == ST_SEARCH) begin
      if (flag_ok) begin
        flagged      <= 1'b1;
        flagged_addr <= addr_q;
      end
      if (last_step) begin
        not_tracked <= !(found || take);
      end
    end
    if (state == ST_WRAP) begin
      scan_total <= {2'b00, failed_cnt} + {2'b00, sudo_cnt} + {2'b00, ssh_cnt};
    end
  end

endmodule

### rtl/flt_checker.sv
// Port-level checker for the failed-login source tracker, bound to the top level.
// Depends only on the top level's ports.
module flt_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic        flagged,
  input logic [31:0] flagged_addr,
  input logic        not_tracked,
  input logic [31:0] scan_failed,
  input logic [31:0] scan_sudo,
  input logic [31:0] scan_ssh,
  input logic [33:0] scan_total
);

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("Accepted transaction did not raise busy.");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("Result shown while still busy.");

  a_flag_addr: assert property (@(posedge clk) disable iff (rst)
    (done && !flagged) |-> (flagged_addr == 32'd0))
    else $error("Flag address set without a flag.");

  a_flag_tracked: assert property (@(posedge clk) disable iff (rst)
    (done && flagged) |-> !not_tracked)
    else $error("Source both flagged and not tracked.");

  a_total_sum: assert property (@(posedge clk) disable iff (rst)
    done |-> (scan_total == ({2'b00, scan_failed} + {2'b00, scan_sudo} +
                             {2'b00, scan_ssh})))
    else $error("Total does not match the scan counters.");

endmodule

bind failed_login_source_tracker flt_checker u_flt_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .done         (done),
  .flagged      (flagged),
  .flagged_addr (flagged_addr),
  .not_tracked  (not_tracked),
  .scan_failed  (scan_failed),
  .scan_sudo    (scan_sudo),
  .scan_ssh     (scan_ssh),
  .scan_total   (scan_total)
);

### tb/sv/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for failed_login_source_tracker: drives classified log events,
// predicts each report in a scoreboard class and compares it with the block's output.
// Depends on flt_pkg and the failed_login_source_tracker RTL.

typedef enum logic {
  LOG_LINE   = 1'b0,
  BEGIN_SCAN = 1'b1
} req_kind_t;

typedef struct packed {
  req_kind_t   req_type;
  logic        failed_password;
  logic        has_source;
  logic        source_valid;
  logic [31:0] source_addr;
  logic        mentions_sudo;
  logic        mentions_ssh;
} log_event_t;

typedef struct packed {
  logic        flagged;
  logic [31:0] flagged_addr;
  logic        not_tracked;
  logic [31:0] scan_failed;
  logic [31:0] scan_sudo;
  logic [31:0] scan_ssh;
  logic [33:0] scan_total;
} scan_report_t;

class login_ledger;
  bit [15:0]    flag_level = 16'd3;
  int           row_of [bit [31:0]];
  bit [15:0]    fail_tally [flt_pkg::TABLE_DEPTH];
  bit           seen_this_scan [flt_pkg::TABLE_DEPTH];
  int           rows_used;
  int           flags_issued;
  bit [31:0]    fail_lines;
  bit [31:0]    sudo_lines;
  bit [31:0]    ssh_lines;
  scan_report_t pending_reports [$];
  int           mismatches;

  function bit [31:0] bump(bit [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  function void note_event(log_event_t ev);
    scan_report_t r = '0;
    bit count_side = 1'b1;
    int row = -1;
    if (ev.req_type == BEGIN_SCAN) begin
      foreach (seen_this_scan[i]) seen_this_scan[i] = 1'b0;
      flags_issued = 0;
      fail_lines = '0;
      sudo_lines = '0;
      ssh_lines = '0;
    end else begin
      if (ev.failed_password) begin
        fail_lines = bump(fail_lines);
        if (ev.has_source && !ev.source_valid) begin
          count_side = 1'b0;
        end else if (ev.has_source) begin
          if (row_of.exists(ev.source_addr)) begin
            row = row_of[ev.source_addr];
          end else if (rows_used < flt_pkg::TABLE_DEPTH) begin
            row = rows_used;
            row_of[ev.source_addr] = row;
            fail_tally[row] = '0;
            seen_this_scan[row] = 1'b0;
            rows_used++;
          end
          if (row < 0) begin
            r.not_tracked = 1'b1;
          end else begin
            if (fail_tally[row] != 16'hFFFF) fail_tally[row]++;
            if (fail_tally[row] >= flag_level && !seen_this_scan[row] &&
                flags_issued < flt_pkg::MAX_FLAGS) begin
              seen_this_scan[row] = 1'b1;
              flags_issued++;
              r.flagged = 1'b1;
              r.flagged_addr = ev.source_addr;
            end
          end
        end
      end
      if (count_side) begin
        if (ev.mentions_sudo) sudo_lines = bump(sudo_lines);
        if (ev.mentions_ssh) ssh_lines = bump(ssh_lines);
      end
    end
    r.scan_failed = fail_lines;
    r.scan_sudo = sudo_lines;
    r.scan_ssh = ssh_lines;
    r.scan_total = {2'b00, fail_lines} + {2'b00, sudo_lines} + {2'b00, ssh_lines};
    pending_reports.push_back(r);
  endfunction

  function void check_field(string name, bit [63:0] want, bit [63:0] got);
    if (want != got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  function void check_report(scan_report_t got);
    scan_report_t want;
    if (pending_reports.size() == 0) begin
      $error("report with no transaction outstanding");
      mismatches++;
      return;
    end
    want = pending_reports.pop_front();
    check_field("flagged", want.flagged, got.flagged);
    check_field("flagged_addr", want.flagged_addr, got.flagged_addr);
    check_field("not_tracked", want.not_tracked, got.not_tracked);
    check_field("scan_failed", want.scan_failed, got.scan_failed);
    check_field("scan_sudo", want.scan_sudo, got.scan_sudo);
    check_field("scan_ssh", want.scan_ssh, got.scan_ssh);
    check_field("scan_total", want.scan_total, got.scan_total);
  endfunction
endclass

module tb;
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic        req_type = 1'b0;
  logic        failed_password = 1'b0;
  logic        has_source = 1'b0;
  logic        source_valid = 1'b0;
  logic [31:0] source_addr = '0;
  logic        mentions_sudo = 1'b0;
  logic        mentions_ssh = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;
  logic        done;
  logic        flagged;
  logic [31:0] flagged_addr;
  logic        not_tracked;
  logic [31:0] scan_failed;
  logic [31:0] scan_sudo;
  logic [31:0] scan_ssh;
  logic [33:0] scan_total;

  login_ledger ledger = new();
  bit [31:0]   addr_pool [64];
  int unsigned idle_pct = 0;

  failed_login_source_tracker dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .req_type(req_type), .failed_password(failed_password), .has_source(has_source),
    .source_valid(source_valid), .source_addr(source_addr),
    .mentions_sudo(mentions_sudo), .mentions_ssh(mentions_ssh),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .done(done), .flagged(flagged), .flagged_addr(flagged_addr),
    .not_tracked(not_tracked), .scan_failed(scan_failed),
    .scan_sudo(scan_sudo), .scan_ssh(scan_ssh),
    .scan_total(scan_total)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin : report_watch
    scan_report_t got;
    got.flagged = flagged;
    got.flagged_addr = flagged_addr;
    got.not_tracked = not_tracked;
    got.scan_failed = scan_failed;
    got.scan_sudo = scan_sudo;
    got.scan_ssh = scan_ssh;
    got.scan_total = scan_total;
    if (!rst && done) ledger.check_report(got);
  end

  function automatic log_event_t mk_event(req_kind_t kind, bit failed, bit has, bit valid,
                                          bit [31:0] addr, bit sudo, bit ssh);
    log_event_t ev;
    ev.req_type = kind;
    ev.failed_password = failed;
    ev.has_source = has;
    ev.source_valid = valid;
    ev.source_addr = addr;
    ev.mentions_sudo = sudo;
    ev.mentions_ssh = ssh;
    return ev;
  endfunction

  // fresh_pct is the share of sources drawn fully at random instead of from the pool.
  function automatic log_event_t random_event(int unsigned fresh_pct);
    log_event_t ev;
    bit [31:0] addr;
    if ($urandom_range(0, 99) < fresh_pct) addr = $urandom;
    else addr = addr_pool[$urandom_range(0, 63)];
    ev = mk_event(LOG_LINE, $urandom_range(0, 9) < 7, $urandom_range(0, 9) < 9,
                  $urandom_range(0, 9) < 8, addr, 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)));
    if ($urandom_range(0, 99) < 3) ev.req_type = BEGIN_SCAN;
    return ev;
  endfunction

  task automatic drive_event(input log_event_t ev);
    int unsigned gap;
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      gap = $urandom_range(1, 8);
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start <= 1'b1;
    req_type <= ev.req_type;
    failed_password <= ev.failed_password;
    has_source <= ev.has_source;
    source_valid <= ev.source_valid;
    source_addr <= ev.source_addr;
    mentions_sudo <= ev.mentions_sudo;
    mentions_ssh <= ev.mentions_ssh;
    do @(posedge clk); while (busy);
    ledger.note_event(ev);
  endtask

  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (ledger.pending_reports.size() != 0) @(posedge clk);
  endtask

  task automatic write_threshold(input bit [15:0] level);
    if (idle_pct != 0) repeat ($urandom_range(1, 8)) @(negedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= level;
    do @(posedge clk); while (!cfg_ready);
    ledger.flag_level = level;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_phase(input bit [15:0] level, input int unsigned count,
                              input int unsigned fresh_pct);
    drain();
    write_threshold(level);
    repeat (count) drive_event(random_event(fresh_pct));
  endtask

  initial begin : stimulus
    bit [31:0] addr;
    foreach (addr_pool[i]) addr_pool[i] = $urandom;
    addr_pool[0] = 32'h0000_0000;
    addr_pool[1] = 32'hFFFF_FFFF;
    addr_pool[2] = 32'hAAAA_AAAA;
    addr_pool[3] = 32'h5555_5555;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    drive_event(mk_event(BEGIN_SCAN, 1, 1, 1, 32'hFFFF_FFFF, 1, 1));
    drive_event(mk_event(LOG_LINE, 0, 1, 1, 32'h1234_5678, 1, 1));
    drive_event(mk_event(LOG_LINE, 1, 0, 1, 32'h1234_5678, 1, 1));
    drive_event(mk_event(LOG_LINE, 1, 1, 0, 32'h1234_5678, 1, 1));
    repeat (3) drive_event(mk_event(LOG_LINE, 1, 1, 1, 32'h0000_0000, 1, 0));
    repeat (3) drive_event(mk_event(LOG_LINE, 1, 1, 1, 32'hFFFF_FFFF, 0, 1));
    drive_event(mk_event(LOG_LINE, 1, 1, 1, 32'h0000_0000, 0, 0));
    drive_event(mk_event(BEGIN_SCAN, 0, 0, 0, 32'h0000_0000, 0, 0));
    drive_event(mk_event(LOG_LINE, 1, 1, 1, 32'h0000_0000, 1, 1));
    drive_event(mk_event(LOG_LINE, 0, 0, 0, 32'h0000_0000, 0, 0));
    drain();
    write_threshold(16'd1);
    drive_event(mk_event(LOG_LINE, 1, 1, 1, 32'hA5A5_A5A5, 1, 1));
    drive_event(mk_event(LOG_LINE, 1, 1, 1, 32'hFFFF_FFFF, 0, 0));
    drain();
    write_threshold(16'd0);
    drive_event(mk_event(LOG_LINE, 1, 1, 1, 32'h5A5A_5A5A, 0, 1));
    drain();
    write_threshold(16'hFFFF);
    drive_event(mk_event(BEGIN_SCAN, 0, 0, 0, 32'h0000_0000, 0, 0));
    drive_event(mk_event(LOG_LINE, 1, 1, 1, 32'h0000_0000, 1, 0));

    idle_pct = 30;
    random_phase(16'd2, 30, 10);
    idle_pct = 0;
    random_phase(16'd0, 30, 10);
    idle_pct = 40;
    random_phase(16'hFFFF, 30, 10);
    random_phase(16'd1, 30, 10);
    idle_pct = 20;
    random_phase(16'($urandom_range(2, 8)), 30, 10);
    random_phase(16'($urandom), 30, 10);
    random_phase(16'd3, 30, 10);

    // Add many new sources in one scan at a threshold of one to run into
    // the per-scan flag limit.
    drain();
    write_threshold(16'd1);
    drive_event(mk_event(BEGIN_SCAN, 0, 0, 0, 32'h0000_0000, 0, 0));
    repeat (flt_pkg::MAX_FLAGS + 8) begin
      do addr = $urandom; while (ledger.row_of.exists(addr));
      drive_event(mk_event(LOG_LINE, 1, 1, 1, addr, 1'($urandom_range(0, 1)),
                           1'($urandom_range(0, 1))));
    end

    idle_pct = 30;
    random_phase(16'($urandom_range(1, 6)), 20, 50);
    random_phase(16'd2, 20, 50);
    random_phase(16'hFFFF, 15, 50);
    idle_pct = 0;
    random_phase(16'd1, 25, 50);

    drain();
    repeat (flt_pkg::TABLE_DEPTH + 16) @(posedge clk);
    if (ledger.pending_reports.size() != 0)
      $error("%0d reports never arrived", ledger.pending_reports.size());
    if (ledger.mismatches == 0 && ledger.pending_reports.size() == 0) begin
      $display("failed_login_source_tracker: match");
    end else begin
      $display("failed_login_source_tracker: mismatch");
    end
    $finish;
  end

  initial begin : watchdog
    #(100_000_000);
    $display("failed_login_source_tracker: mismatch");
    $finish;
  end
endmodule

### filelist.f
rtl/flt_pkg.sv
rtl/flt_cell.sv
rtl/flt_chain.sv
rtl/failed_login_source_tracker.sv
rtl/flt_checker.sv
tb/sv/tb.sv
